// ===== rtl/mtep_pkg.sv =====
// shared types, constants and step functions for the moments to ellipse pipeline
`default_nettype none

package mtep_pkg;

  localparam int MOMENT_WIDTH = 32;
  localparam int MW_EFF = (MOMENT_WIDTH < 32) ? MOMENT_WIDTH : 32;
  localparam logic [31:0] MOM_MASK = 32'((64'd1 << MW_EFF) - 64'd1);

  localparam int FRONT_ST = 4;
  localparam int T2_STEPS = 49;
  localparam int AX_STEPS = 33;
  localparam int R1_STEPS = 64;
  localparam int R2_STEPS = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int DIV_STEPS = 30;
  localparam int BACK_ST = R1_STEPS + R2_STEPS;
  localparam int PIPE_ST = FRONT_ST + BACK_ST;

  localparam logic signed [31:0] PI27 = 32'sd421657428;
  localparam logic signed [31:0] NEG_PI27 = -32'sd421657428;
  localparam logic [30:0] Q30_ONE = 31'h4000_0000;

  // square root state, radicand consumed two bits at a time from the top
  typedef struct packed {
    logic [127:0] rad;
    logic [63:0]  root;
    logic [65:0]  rem;
  } sq_t;

  typedef struct packed {
    logic signed [32:0] d;
    logic signed [31:0] z;
    logic [32:0]        t;
    logic [31:0]        dmag;
    logic [31:0]        zmag;
    logic [64:0]        s;
    logic [63:0]        det;
    logic               deg;
    logic               inv;
  } front_t;

  typedef struct packed {
    logic [32:0] major_root;
    logic [32:0] minor_root;
    logic [31:0] rad_root;
    logic        deg;
    logic        inv;
  } roots_t;

  typedef struct packed {
    logic [31:0]        major_axis;
    logic [31:0]        minor_axis;
    logic signed [29:0] angle;
    logic signed [31:0] dist_e1;
    logic signed [31:0] dist_e2;
    logic [31:0]        radius;
    logic               degenerate;
    logic               invalid;
  } res_t;

  function automatic sq_t sq_load(input logic [127:0] rad);
    sq_t r;
    r.rad = rad;
    r.root = '0;
    r.rem = '0;
    return r;
  endfunction

  // one restoring root bit
  function automatic sq_t sq_step(input sq_t a);
    sq_t r;
    logic [67:0] acc;
    logic [67:0] trial;
    acc = {a.rem, a.rad[127:126]};
    trial = {2'b00, a.root, 2'b01};
    r.rad = {a.rad[125:0], 2'b00};
    if (acc >= trial) begin
      r.rem = 66'(acc - trial);
      r.root = {a.root[62:0], 1'b1};
    end else begin
      r.rem = acc[65:0];
      r.root = {a.root[62:0], 1'b0};
    end
    return r;
  endfunction

  // atan(2^-i) in units of 2^-27
  function automatic logic signed [31:0] cordic_ang(input int i);
    logic signed [31:0] a;
    unique case (i)
      0: a = 32'sd105414357;
      1: a = 32'sd62229729;
      2: a = 32'sd32880480;
      3: a = 32'sd16690645;
      4: a = 32'sd8377711;
      5: a = 32'sd4192939;
      6: a = 32'sd2096981;
      7: a = 32'sd1048555;
      8: a = 32'sd524285;
      9: a = 32'sd262144;
      default: a = 32'(64'sd1 <<< (27 - i));
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/moments_to_ellipse_params.sv =====
// top level: second moments to ellipse axes, angle, distortion and radius
`default_nettype none

// Takes one word of second moments per clock and returns one word of ellipse
// parameters per clock while m_tready stays high. A word passes 4 front stages
// (differences, 32x32 products, sums), 96 stages set by the radius path, two
// bit-serial square roots of 64 and 32 result bits at one root bit per stage, and
// the output register. The axis roots, the cordic and the dividers run alongside
// within the same 96 stages. A skid register behind the output keeps the pipeline
// running while one word waits; s_tready drops only while that skid register is
// full. min_trace is written through cfg_we/cfg_wdata and resets to 1; the user
// must write it only while the block is empty, which the block does not enforce.
module moments_to_ellipse_params (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [95:0]  s_tdata,   // ixx, iyy, ixy
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [191:0] m_tdata,   // major_axis, minor_axis, angle, dist_e1, dist_e2, radius
  output logic [1:0]   m_tuser,   // degenerate, invalid
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata
);
  import mtep_pkg::*;

  logic [31:0] min_trace;
  logic [PIPE_ST-1:0] v;
  logic adv, push;
  front_t fr;
  roots_t ro;
  logic signed [29:0] angle;
  logic signed [31:0] e1, e2;
  res_t res, out_r, skid_r;
  logic out_v, skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_trace <= 32'd1;
    end else if (cfg_we) begin
      min_trace <= cfg_wdata;
    end
  end

  // whole pipeline moves together unless the skid register holds a word
  assign adv = !skid_v;
  assign s_tready = adv;
  assign push = adv && v[PIPE_ST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[PIPE_ST-2:0], s_tvalid};
    end
  end

  mtep_front u_front (
    .clk       (clk),
    .adv       (adv),
    .mom_data  (s_tdata),
    .min_trace (min_trace),
    .fr        (fr)
  );

  mtep_roots u_roots (
    .clk (clk),
    .adv (adv),
    .fr  (fr),
    .ro  (ro)
  );

  mtep_cordic u_cordic (
    .clk   (clk),
    .adv   (adv),
    .fr    (fr),
    .angle (angle)
  );

  mtep_div u_div (
    .clk (clk),
    .adv (adv),
    .fr  (fr),
    .e1  (e1),
    .e2  (e2)
  );

  always_comb begin
    res.major_axis = ro.major_root[32] ? '1 : ro.major_root[31:0];
    res.minor_axis = ro.minor_root[32] ? '1 : ro.minor_root[31:0];
    res.angle      = angle;
    res.dist_e1    = ro.deg ? '0 : e1;
    res.dist_e2    = ro.deg ? '0 : e2;
    res.radius     = (ro.deg || ro.inv) ? '0 : ro.rad_root;
    res.degenerate = ro.deg;
    res.invalid    = ro.inv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!out_v || m_tready) begin
      if (skid_v) begin
        out_v <= 1'b1;
        skid_v <= 1'b0;
      end else begin
        out_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v || m_tready) begin
      if (skid_v) begin
        out_r <= skid_r;
      end else if (push) begin
        out_r <= res;
      end
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata = {2'b00, out_r.radius, out_r.dist_e2, out_r.dist_e1, out_r.angle,
                    out_r.minor_axis, out_r.major_axis};
  assign m_tuser = {out_r.invalid, out_r.degenerate};

  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v)
    else $error("skid word held with no output word");

  a_degenerate_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_r.degenerate) |->
      (out_r.dist_e1 == '0 && out_r.dist_e2 == '0 && out_r.radius == '0))
    else $error("degenerate word with nonzero distortion or radius");

  a_invalid_zeroed: assert property (@(posedge clk) disable iff (rst)
    (out_v && out_r.invalid) |-> (out_r.minor_axis == '0 && out_r.radius == '0))
    else $error("invalid word with nonzero minor axis or radius");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_r.angle <= PI27 && out_r.angle >= NEG_PI27))
    else $error("angle outside half turn");

  a_major_not_below_minor: assert property (@(posedge clk) disable iff (rst)
    out_v |-> (out_r.major_axis >= out_r.minor_axis))
    else $error("minor axis exceeds major axis");

endmodule

`default_nettype wire

// ===== rtl/mtep_front.sv =====
// front stages: differences, magnitudes, products, flags
`default_nettype none

module mtep_front (
  input  logic                 clk,
  input  logic                 adv,
  input  logic [95:0]          mom_data,
  input  logic [31:0]          min_trace,
  output mtep_pkg::front_t     fr
);
  import mtep_pkg::*;

  typedef struct packed {
    logic [31:0]        xx;
    logic [31:0]        yy;
    logic signed [31:0] z;
    logic signed [32:0] d;
    logic [32:0]        t;
  } f0_t;

  typedef struct packed {
    logic [63:0]        p;
    logic [31:0]        dmag;
    logic [31:0]        zmag;
    logic signed [32:0] d;
    logic signed [31:0] z;
    logic [32:0]        t;
    logic               deg;
  } f1_t;

  typedef struct packed {
    logic [63:0]        p;
    logic [63:0]        dd;
    logic [63:0]        q;
    logic [31:0]        dmag;
    logic [31:0]        zmag;
    logic signed [32:0] d;
    logic signed [31:0] z;
    logic [32:0]        t;
    logic               deg;
  } f2_t;

  f0_t f0, f0_next;
  f1_t f1, f1_next;
  f2_t f2, f2_next;
  front_t f3_next;

  logic [31:0] xx_in, yy_in, z_sh;
  logic signed [32:0] d_neg, z_neg;

  // unused top bits dropped, cross moment sign extended from its top bit
  assign xx_in = mom_data[31:0] & MOM_MASK;
  assign yy_in = mom_data[63:32] & MOM_MASK;
  assign z_sh  = mom_data[95:64] << (32 - MW_EFF);

  always_comb begin
    f0_next.xx = xx_in;
    f0_next.yy = yy_in;
    f0_next.z  = $signed(z_sh) >>> (32 - MW_EFF);
    f0_next.d  = $signed({1'b0, xx_in}) - $signed({1'b0, yy_in});
    f0_next.t  = {1'b0, xx_in} + {1'b0, yy_in};
  end

  assign d_neg = -f0.d;
  assign z_neg = -{f0.z[31], f0.z};

  always_comb begin
    f1_next.p    = f0.xx * f0.yy;
    f1_next.dmag = f0.d[32] ? d_neg[31:0] : f0.d[31:0];
    f1_next.zmag = f0.z[31] ? z_neg[31:0] : f0.z;
    f1_next.d    = f0.d;
    f1_next.z    = f0.z;
    f1_next.t    = f0.t;
    f1_next.deg  = (f0.t < {1'b0, min_trace}) || (f0.t == '0);
  end

  always_comb begin
    f2_next.p    = f1.p;
    f2_next.dd   = f1.dmag * f1.dmag;
    f2_next.q    = f1.zmag * f1.zmag;
    f2_next.dmag = f1.dmag;
    f2_next.zmag = f1.zmag;
    f2_next.d    = f1.d;
    f2_next.z    = f1.z;
    f2_next.t    = f1.t;
    f2_next.deg  = f1.deg;
  end

  // q never exceeds 2^62, so four times it fits 65 bits
  always_comb begin
    f3_next.d    = f2.d;
    f3_next.z    = f2.z;
    f3_next.t    = f2.t;
    f3_next.dmag = f2.dmag;
    f3_next.zmag = f2.zmag;
    f3_next.s    = {1'b0, f2.dd} + {f2.q[62:0], 2'b00};
    f3_next.det  = f2.p - f2.q;
    f3_next.deg  = f2.deg;
    f3_next.inv  = f2.q > f2.p;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0 <= f0_next;
      f1 <= f1_next;
      f2 <= f2_next;
      fr <= f3_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mtep_roots.sv =====
// bit-serial square roots: axis lengths and radius
`default_nettype none

module mtep_roots (
  input  logic               clk,
  input  logic               adv,
  input  mtep_pkg::front_t   fr,
  output mtep_pkg::roots_t   ro
);
  import mtep_pkg::*;

  typedef struct packed {
    sq_t         a;
    sq_t         b;
    sq_t         c;
    logic [48:0] tq;
    logic        deg;
    logic        inv;
  } rt_t;

  rt_t st [BACK_ST];
  rt_t init;

  // a: root of s<<32, then major; b: minor; c: det root then its root
  always_comb begin
    init.a   = sq_load({1'b0, fr.s, 32'b0, 30'b0});
    init.b   = sq_load('0);
    init.c   = sq_load({fr.det, 64'b0});
    init.tq  = {fr.t, 16'b0};
    init.deg = fr.deg;
    init.inv = fr.inv;
  end

  for (genvar j = 0; j < BACK_ST; j++) begin : g_stage
    rt_t prv, nx;

    if (j == 0) begin : g_first
      assign prv = init;
    end else begin : g_rest
      assign prv = st[j-1];
    end

    always_comb begin : c_nx
      logic [48:0] t2;
      logic [49:0] sum;
      logic [48:0] mn;
      t2  = prv.a.root[48:0];
      sum = {1'b0, prv.tq} + {1'b0, t2};
      mn  = (!prv.inv && (t2 < prv.tq)) ? prv.tq - t2 : '0;
      nx = prv;
      if (j < T2_STEPS) begin
        nx.a = sq_step(prv.a);
      end else if (j == T2_STEPS) begin
        nx.a = sq_load({1'b0, sum, 15'b0, 62'b0});
        nx.b = sq_load({2'b0, mn, 15'b0, 62'b0});
      end else if (j <= T2_STEPS + AX_STEPS) begin
        nx.a = sq_step(prv.a);
        nx.b = sq_step(prv.b);
      end
      if (j == R1_STEPS) begin
        nx.c = sq_step(sq_load({prv.c.root, 64'b0}));
      end else begin
        nx.c = sq_step(prv.c);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nx;
      end
    end
  end

  assign ro.major_root = st[BACK_ST-1].a.root[32:0];
  assign ro.minor_root = st[BACK_ST-1].b.root[32:0];
  assign ro.rad_root   = st[BACK_ST-1].c.root[31:0];
  assign ro.deg        = st[BACK_ST-1].deg;
  assign ro.inv        = st[BACK_ST-1].inv;

endmodule

`default_nettype wire

// ===== rtl/mtep_cordic.sv =====
// pipelined cordic vectoring for the position angle
`default_nettype none

module mtep_cordic (
  input  logic               clk,
  input  logic               adv,
  input  mtep_pkg::front_t   fr,
  output logic signed [29:0] angle
);
  import mtep_pkg::*;

  typedef struct packed {
    logic signed [59:0] x;
    logic signed [59:0] y;
    logic signed [31:0] acc;
  } cs_t;

  cs_t st [BACK_ST];
  cs_t init;
  logic signed [59:0] xi, yi;

  assign xi = 60'(fr.d) <<< 24;
  assign yi = 60'(fr.z) <<< 25;

  // left half plane folded over by a half turn
  always_comb begin
    if (xi < 0) begin
      init.acc = (yi >= 0) ? PI27 : NEG_PI27;
      init.x = -xi;
      init.y = -yi;
    end else begin
      init.acc = '0;
      init.x = xi;
      init.y = yi;
    end
  end

  for (genvar j = 0; j < BACK_ST; j++) begin : g_stage
    cs_t prv, nx;

    if (j == 0) begin : g_first
      assign prv = init;
    end else begin : g_rest
      assign prv = st[j-1];
    end

    always_comb begin
      nx = prv;
      if (j == 0) begin
        nx = init;
      end else if (j <= CORDIC_STEPS) begin
        if (prv.y > 0) begin
          nx.x = prv.x + (prv.y >>> (j - 1));
          nx.y = prv.y - (prv.x >>> (j - 1));
          nx.acc = prv.acc + cordic_ang(j - 1);
        end else if (prv.y < 0) begin
          nx.x = prv.x - (prv.y >>> (j - 1));
          nx.y = prv.y + (prv.x >>> (j - 1));
          nx.acc = prv.acc - cordic_ang(j - 1);
        end
      end else if (j == CORDIC_STEPS + 1) begin
        if (prv.acc > PI27) begin
          nx.acc = PI27;
        end else if (prv.acc < NEG_PI27) begin
          nx.acc = NEG_PI27;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nx;
      end
    end
  end

  assign angle = st[BACK_ST-1].acc[29:0];

endmodule

`default_nettype wire

// ===== rtl/mtep_div.sv =====
// restoring dividers for the two distortion ratios
`default_nettype none

module mtep_div (
  input  logic               clk,
  input  logic               adv,
  input  mtep_pkg::front_t   fr,
  output logic signed [31:0] e1,
  output logic signed [31:0] e2
);
  import mtep_pkg::*;

  typedef struct packed {
    logic [32:0]        rem;
    logic [29:0]        q;
    logic               sat;
    logic               neg;
    logic signed [31:0] val;
  } lane_t;

  typedef struct packed {
    lane_t       l1;
    lane_t       l2;
    logic [32:0] t;
  } ds_t;

  // a numerator of at least the trace gives exactly one
  function automatic lane_t lane_init(input logic [32:0] mag, input logic [32:0] t,
                                      input logic neg);
    lane_t l;
    l.rem = mag;
    l.q = '0;
    l.sat = mag >= t;
    l.neg = neg;
    l.val = '0;
    return l;
  endfunction

  function automatic lane_t lane_step(input lane_t l, input logic [32:0] t);
    lane_t r;
    logic [33:0] r2;
    r = l;
    r2 = {l.rem, 1'b0};
    if (r2 >= {1'b0, t}) begin
      r.rem = 33'(r2 - {1'b0, t});
      r.q = {l.q[28:0], 1'b1};
    end else begin
      r.rem = r2[32:0];
      r.q = {l.q[28:0], 1'b0};
    end
    return r;
  endfunction

  function automatic lane_t lane_fin(input lane_t l);
    lane_t r;
    logic [30:0] mag;
    logic signed [31:0] v;
    r = l;
    mag = l.sat ? Q30_ONE : {1'b0, l.q};
    v = $signed({1'b0, mag});
    r.val = l.neg ? -v : v;
    return r;
  endfunction

  ds_t st [BACK_ST];
  ds_t init;

  always_comb begin
    init.t = fr.t;
    init.l1 = lane_init({1'b0, fr.dmag}, fr.t, fr.d[32]);
    init.l2 = lane_init({fr.zmag, 1'b0}, fr.t, fr.z[31]);
  end

  for (genvar j = 0; j < BACK_ST; j++) begin : g_stage
    ds_t prv, nx;

    if (j == 0) begin : g_first
      assign prv = init;
    end else begin : g_rest
      assign prv = st[j-1];
    end

    always_comb begin
      nx = prv;
      if ((j >= 1) && (j <= DIV_STEPS)) begin
        nx.l1 = lane_step(prv.l1, prv.t);
        nx.l2 = lane_step(prv.l2, prv.t);
      end else if (j == DIV_STEPS + 1) begin
        nx.l1 = lane_fin(prv.l1);
        nx.l2 = lane_fin(prv.l2);
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st[j] <= nx;
      end
    end
  end

  assign e1 = st[BACK_ST-1].l1.val;
  assign e2 = st[BACK_ST-1].l2.val;

endmodule

`default_nettype wire

// ===== test/ellipse_checker.sv =====
// checker: watches the moment and ellipse streams, predicts each ellipse word and compares
module ellipse_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [95:0]  s_tdata,   // ixx, iyy, ixy
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [191:0] m_tdata,   // major_axis, minor_axis, angle, dist_e1, dist_e2, radius
  input  logic [1:0]   m_tuser,   // degenerate, invalid
  input  logic         cfg_we,
  input  logic [31:0]  cfg_wdata,
  output int           mismatches,
  output int           pending,
  output int           results_seen
);
  import mtep_pkg::*;

  localparam longint HALF_PI = 64'sd421657428;

  res_t        expected_q[$];
  logic [31:0] trace_floor;

  function automatic logic [63:0] root128(input logic [127:0] n);
    logic [63:0] r;
    logic [63:0] c;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if ({64'd0, c} * {64'd0, c} <= n) r = c;
    end
    return r;
  endfunction

  function automatic longint arc_step(input int i);
    longint tab [10];
    tab = '{105414357, 62229729, 32880480, 16690645, 8377711,
            4192939, 2096981, 1048555, 524285, 262144};
    if (i < 10) return tab[i];
    return longint'(64'sd1 <<< (27 - i));
  endfunction

  // cordic vectoring of (d, 2z) gives atan2 at 2^-27, read as theta at 2^-28
  function automatic longint half_angle_of(input longint d, input longint z);
    longint x, y, acc, nx, ny, ang;
    x = d * 64'sd16777216;
    y = z * 64'sd33554432;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? HALF_PI : -HALF_PI;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 28; i++) begin
      ang = arc_step(i);
      nx = x;
      ny = y;
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); acc += ang;
      end else if (y < 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); acc -= ang;
      end
      x = nx;
      y = ny;
    end
    if (acc > HALF_PI) acc = HALF_PI;
    if (acc < -HALF_PI) acc = -HALF_PI;
    return acc;
  endfunction

  function automatic longint q30_ratio(input logic [63:0] mag, input bit neg,
                                       input logic [63:0] t);
    logic [63:0] r;
    r = (mag << 30) / t;
    if (r > (64'd1 << 30)) r = 64'd1 << 30;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic res_t ellipse_of(input logic [95:0] w, input logic [31:0] floor_t);
    res_t        r;
    longint      d, z, e1, e2, ang;
    logic [63:0] xx, yy, t, dmag, zmag, p, q, t2, tq, major, minor, radius;
    logic [127:0] s;
    bit          inv, deg;
    xx = {32'd0, w[31:0]};
    yy = {32'd0, w[63:32]};
    z = longint'($signed(w[95:64]));
    d = longint'(xx) - longint'(yy);
    t = xx + yy;
    dmag = (d < 0) ? -d : d;
    zmag = (z < 0) ? -z : z;
    p = xx * yy;
    q = zmag * zmag;
    inv = q > p;
    deg = (t < {32'd0, floor_t}) || (t == 0);
    s = {64'd0, dmag * dmag} + ({64'd0, q} << 2);
    t2 = root128(s << 32);
    tq = t << 16;
    major = root128({64'd0, tq + t2} << 15);
    minor = 0;
    radius = 0;
    e1 = 0;
    e2 = 0;
    if (major > 64'hFFFF_FFFF) major = 64'hFFFF_FFFF;
    if (!inv && t2 < tq) begin
      minor = root128({64'd0, tq - t2} << 15);
      if (minor > 64'hFFFF_FFFF) minor = 64'hFFFF_FFFF;
    end
    if (!deg) begin
      e1 = q30_ratio(dmag, d < 0, t);
      e2 = q30_ratio(2 * zmag, z < 0, t);
      if (!inv) radius = root128({64'd0, root128({p - q, 64'd0})});
    end
    ang = half_angle_of(d, z);
    r.major_axis = major[31:0];
    r.minor_axis = minor[31:0];
    r.angle = ang[29:0];
    r.dist_e1 = e1[31:0];
    r.dist_e2 = e2[31:0];
    r.radius = radius[31:0];
    r.degenerate = deg;
    r.invalid = inv;
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst) begin
      trace_floor <= 32'd1;
      expected_q.delete();
      mismatches <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_we) trace_floor <= cfg_wdata;
      if (s_tvalid && s_tready) expected_q.push_back(ellipse_of(s_tdata, trace_floor));
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        got.major_axis = m_tdata[31:0];
        got.minor_axis = m_tdata[63:32];
        got.angle = m_tdata[93:64];
        got.dist_e1 = m_tdata[125:94];
        got.dist_e2 = m_tdata[157:126];
        got.radius = m_tdata[189:158];
        got.degenerate = m_tuser[0];
        got.invalid = m_tuser[1];
        if (expected_q.size() == 0) begin
          $error("ellipse word with none expected: %h %b", m_tdata, m_tuser);
          mismatches <= mismatches + 1;
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            mismatches <= mismatches + 1;
            if (got.major_axis != want.major_axis)
              $error("major_axis exp %h got %h", want.major_axis, got.major_axis);
            if (got.minor_axis != want.minor_axis)
              $error("minor_axis exp %h got %h", want.minor_axis, got.minor_axis);
            if (got.angle != want.angle)
              $error("angle exp %0d got %0d", want.angle, got.angle);
            if (got.dist_e1 != want.dist_e1)
              $error("dist_e1 exp %0d got %0d", want.dist_e1, got.dist_e1);
            if (got.dist_e2 != want.dist_e2)
              $error("dist_e2 exp %0d got %0d", want.dist_e2, got.dist_e2);
            if (got.radius != want.radius)
              $error("radius exp %h got %h", want.radius, got.radius);
            if (got.degenerate != want.degenerate)
              $error("degenerate exp %b got %b", want.degenerate, got.degenerate);
            if (got.invalid != want.invalid)
              $error("invalid exp %b got %b", want.invalid, got.invalid);
          end
        end
      end
    end
  end

  always_comb pending = expected_q.size();

endmodule

// ===== test/tb_top.sv =====
// testbench top: drives moments and trace floor settings, gives the verdict
module tb_top;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 130;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [95:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [191:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_wdata = '0;

  int mismatches, pending, results_seen;
  int burst_left = 0;
  int words_sent = 0;
  int idle_cycles = 0;
  int stall_hold = 0;

  always #5 clk = ~clk;

  moments_to_ellipse_params u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  ellipse_checker u_chk (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .mismatches(mismatches), .pending(pending), .results_seen(results_seen)
  );

  // receiver: alternating ready and stall runs, with some long free-flowing stretches
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      m_tready <= ~m_tready;
      if (m_tready) stall_hold <= $urandom_range(0, 25);
      else stall_hold <= ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                       : $urandom_range(0, 12);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic send_moments(input logic [31:0] ixx, input logic [31:0] iyy,
                              input logic signed [31:0] ixy);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 15);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 20);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata <= {ixy, iyy, ixx};
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
  endtask

  // hold off until every ellipse word is back, then let the pipeline empty
  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_trace_floor(input logic [31:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_random_moments();
    logic [31:0] a, b, m;
    logic signed [31:0] c;
    int sh;
    sh = $urandom_range(0, 31);
    a = $urandom >> sh;
    b = $urandom >> $urandom_range(0, 31);
    case ($urandom_range(0, 9))
      0, 1, 2: send_moments($urandom, $urandom, $urandom);
      3, 4, 5: begin
        // well-formed ellipse: |ixy| no larger than min(ixx, iyy)
        m = (a < b) ? a : b;
        if (m > 32'h7FFF_FFFF) m = 32'h7FFF_FFFF;
        c = (m == 0) ? 0 : $signed($urandom % (m + 1));
        if ($urandom_range(0, 1)) c = -c;
        send_moments(a, b, c);
      end
      6: send_moments(a, a, $urandom_range(0, 1) ? 32'sd0 : $signed($urandom >> 20));
      7: send_moments(a, b, 32'sd0);
      8: send_moments($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $signed($urandom_range(0, 65535)) - 32'sd32768);
      default: send_moments(~($urandom >> 24), ~($urandom >> 24),
                            $urandom_range(0, 1) ? 32'sh7FFF_FFFF - ($urandom >> 24)
                                                 : 32'sh8000_0000 + ($urandom >> 24));
    endcase
  endtask

  initial begin
    logic [31:0] floors [6];
    floors = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h8000_0000, 32'd0};
    floors[5] = $urandom;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed words under the reset floor of one
    send_moments(32'd0, 32'd0, 32'sd0);
    send_moments(32'h0001_0000, 32'h0001_0000, 32'sd0);
    send_moments(32'h0001_0000, 32'h0004_0000, 32'sd0);
    send_moments(32'h0004_0000, 32'h0001_0000, 32'sd0);
    send_moments(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sd0);
    send_moments(32'hFFFF_FFFF, 32'd0, 32'sd0);
    send_moments(32'd0, 32'hFFFF_FFFF, 32'sd0);
    send_moments(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh7FFF_FFFF);
    send_moments(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'sh8000_0000);
    send_moments(32'd0, 32'd0, 32'sh7FFF_FFFF);
    send_moments(32'd0, 32'd0, 32'sh8000_0000);
    send_moments(32'h0001_0000, 32'h0001_0000, 32'sh0002_0000);
    send_moments(32'h0001_0000, 32'h0001_0000, -32'sh0002_0000);
    send_moments(32'h0002_0000, 32'h0002_0000, 32'sh0002_0000);
    send_moments(32'h0003_0000, 32'h0001_0000, -32'sh0001_0000);
    send_moments(32'd1, 32'd0, 32'sd0);
    send_moments(32'd0, 32'd1, 32'sd0);
    send_moments(32'd0, 32'd0, 32'sd1);
    send_moments(32'd0, 32'd0, -32'sd1);
    send_moments(32'h8000_0000, 32'h7FFF_FFFF, -32'sh4000_0000);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain_pipe();
        set_trace_floor(floors[ph]);
      end
      repeat (275) send_random_moments();
    end

    drain_pipe();
    $display("sent %0d moment words, checked %0d ellipse words", words_sent, results_seen);
    $display("trace floors covered: 1, 0, all ones, 1.0, half range and one random value");
    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
